>>> hw/rtl/motor_speed_pid_controller_unit_macros.svh
// Assertion helpers for the speed controller.
`ifndef MOTOR_SPEED_PID_CONTROLLER_UNIT_MACROS_SVH
`define MOTOR_SPEED_PID_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`define MSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define MSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define MSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/msp_pkg.sv
`timescale 1ns / 1ps
package msp_pkg;

  typedef enum logic [2:0] {
    MODE_HALL  = 3'd0,
    MODE_SPEED = 3'd1,
    MODE_RAMP  = 3'd2,
    MODE_CTRL  = 3'd3,
    MODE_START = 3'd4,
    MODE_STOP  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    REG_KP  = 3'd0,
    REG_KI  = 3'd1,
    REG_KD  = 3'd2,
    REG_MAX = 3'd3,
    REG_MIN = 3'd4
  } reg_idx_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_SP_MUL25,
    CMD_SP_RECIP3,
    CMD_SP_MUL60,
    CMD_SP_UPDATE,
    CMD_SP_DIVMUL,
    CMD_SP_REMMUL,
    CMD_SP_AVG,
    CMD_CT_ERR,
    CMD_CT_MULP,
    CMD_CT_MULI,
    CMD_CT_MULD,
    CMD_CT_SUB,
    CMD_CT_CLAMP,
    CMD_CT_DUTYMUL,
    CMD_CT_DUTY
  } step_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SP_RECIP3,
    ST_SP_MUL60,
    ST_SP_UPDATE,
    ST_SP_DIVMUL,
    ST_SP_REMMUL,
    ST_SP_AVG,
    ST_CT_MULP,
    ST_CT_MULI,
    ST_CT_MULD,
    ST_CT_SUB,
    ST_CT_CLAMP,
    ST_CT_DUTYMUL,
    ST_CT_DUTY,
    ST_DONE
  } state_e;

  typedef struct packed {
    step_e step;
    logic  load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
  } dp_status_t;

  typedef struct packed {
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic [12:0]        max_cmd;
    logic [12:0]        min_cmd;
  } cfg_t;

  localparam logic [11:0]        EDGE_MAX       = 12'd4095;
  localparam logic signed [13:0] START_SETPOINT = 14'sd700;
  localparam logic signed [13:0] FAST_STEP      = 14'sd4;
  localparam logic signed [13:0] SLOW_STEP      = 14'sd1;
  localparam logic [12:0]        MAX_CMD_RESET  = 13'd5820;
  localparam logic [7:0]         EDGE_TO_RPM_A  = 8'd25;
  localparam logic [15:0]        RECIP3         = 16'd43691;
  localparam int unsigned        RECIP3_SHIFT   = 17;
  localparam logic [7:0]         EDGE_TO_RPM_B  = 8'd60;
  localparam logic [15:0]        DUTY_RECIP     = 16'd34593;
  localparam int unsigned        DUTY_SHIFT     = 24;

endpackage

>>> hw/rtl/msp_cfg_regs.sv
`timescale 1ns / 1ps
module msp_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output msp_pkg::cfg_t cfg_o
);
  import msp_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp      <= '0;
      cfg_q.ki      <= '0;
      cfg_q.kd      <= '0;
      cfg_q.max_cmd <= MAX_CMD_RESET;
      cfg_q.min_cmd <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_KP:  cfg_q.kp      <= $signed(pwdata);
        REG_KI:  cfg_q.ki      <= $signed(pwdata);
        REG_KD:  cfg_q.kd      <= $signed(pwdata);
        REG_MAX: cfg_q.max_cmd <= pwdata[12:0];
        REG_MIN: cfg_q.min_cmd <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_KP:  prdata = cfg_q.kp;
      REG_KI:  prdata = cfg_q.ki;
      REG_KD:  prdata = cfg_q.kd;
      REG_MAX: prdata = {19'd0, cfg_q.max_cmd};
      REG_MIN: prdata = {19'd0, cfg_q.min_cmd};
      default: prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/msp_datapath.sv
`timescale 1ns / 1ps
module msp_datapath #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msp_pkg::ctl_cmd_t   cmd_i,
  output msp_pkg::dp_status_t status_o,
  input  msp_pkg::cfg_t       cfg_i,
  input  logic [2:0]          in_mode_i,
  input  logic [12:0]         in_target_i,
  input  logic                in_estop_i,
  output logic [47:0]         out_data_o,
  output logic                out_user_o
);
  import msp_pkg::*;

  localparam int PW    = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = 21 + $clog2(WINDOW_DEPTH);
  localparam logic [31:0] RECIP_W = 32'((64'd1 << 32) / WINDOW_DEPTH);

  logic [2:0]  mode_q;
  logic [12:0] target_q;
  logic        estop_q;

  logic [11:0]        edge_q;
  logic [PW-1:0]      pos_q;
  logic               filled_q;
  logic [SUM_W-1:0]   sum_q;
  logic [20:0]        avg_q;
  logic signed [13:0] sp_q;
  logic signed [31:0] integ_q;
  logic signed [22:0] lerr_q;
  logic [5:0]         duty_q;
  logic               run_q;
  logic [WINDOW_DEPTH-1:0] vld_q;

  logic [20:0]        win_mem [WINDOW_DEPTH];
  logic [20:0]        rd_q;
  logic               rdv_q;

  logic signed [65:0] prod_q;
  logic signed [63:0] acc_q;
  logic [20:0]        rpm_q;
  logic [SUM_W-1:0]   q0_q;
  logic signed [22:0] err_q;
  logic signed [23:0] diff_q;
  logic [28:0]        clamp_q;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_d;

  logic signed [22:0] err_d;
  logic signed [32:0] isum;
  logic signed [31:0] integ_d;
  logic [20:0]        old_val;
  logic [SUM_W-1:0]   rem;
  logic signed [63:0] hi_lim;
  logic signed [63:0] lo_lim;
  logic [PW-1:0]      pos_next;

  assign status_o.mode = mode_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      CMD_SP_MUL25: begin
        mul_a = 33'(edge_q);
        mul_b = 33'(EDGE_TO_RPM_A);
      end
      CMD_SP_RECIP3: begin
        mul_a = 33'(prod_q[16:0]);
        mul_b = 33'(RECIP3);
      end
      CMD_SP_MUL60: begin
        mul_a = 33'(prod_q[RECIP3_SHIFT +: 16]);
        mul_b = 33'(EDGE_TO_RPM_B);
      end
      CMD_SP_DIVMUL: begin
        mul_a = 33'(sum_q);
        mul_b = 33'(RECIP_W);
      end
      CMD_SP_REMMUL: begin
        mul_a = 33'(prod_q[32 +: SUM_W]);
        mul_b = 33'(WINDOW_DEPTH);
      end
      CMD_CT_MULP: begin
        mul_a = 33'(cfg_i.kp);
        mul_b = 33'(err_q);
      end
      CMD_CT_MULI: begin
        mul_a = 33'(cfg_i.ki);
        mul_b = 33'(integ_q);
      end
      CMD_CT_MULD: begin
        mul_a = 33'(cfg_i.kd);
        mul_b = 33'(diff_q);
      end
      CMD_CT_DUTYMUL: begin
        mul_a = 33'(clamp_q[28:15]);
        mul_b = 33'(DUTY_RECIP);
      end
      default: ;
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign err_d    = 23'(sp_q) - $signed({2'b00, avg_q});
  assign isum     = 33'(integ_q) + 33'(err_d);
  assign old_val  = rdv_q ? rd_q : '0;
  assign rem      = sum_q - prod_q[SUM_W-1:0];
  assign hi_lim   = $signed({35'd0, cfg_i.max_cmd, 16'd0});
  assign lo_lim   = $signed({35'd0, cfg_i.min_cmd, 16'd0});
  assign pos_next = (pos_q == PW'(WINDOW_DEPTH - 1)) ? '0 : pos_q + 1'b1;

  always_comb begin
    if (isum > 33'sh0_7FFF_FFFF) begin
      integ_d = 32'sh7FFF_FFFF;
    end else if (isum < -33'sh0_8000_0000) begin
      integ_d = -32'sh8000_0000;
    end else begin
      integ_d = isum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q   <= '0;
      pos_q    <= '0;
      filled_q <= 1'b0;
      sum_q    <= '0;
      avg_q    <= '0;
      sp_q     <= '0;
      integ_q  <= '0;
      lerr_q   <= '0;
      duty_q   <= '0;
      run_q    <= 1'b0;
      vld_q    <= '0;
    end else begin
      case (cmd_i.step)
        CMD_EXEC: begin
          case (mode_q)
            MODE_HALL: begin
              if (run_q && edge_q < EDGE_MAX) begin
                edge_q <= edge_q + 1'b1;
              end
            end
            MODE_RAMP: begin
              if (sp_q < $signed({1'b0, target_q})) begin
                sp_q <= sp_q + SLOW_STEP;
              end else if (sp_q > $signed({1'b0, target_q})) begin
                sp_q <= sp_q - (estop_q ? FAST_STEP : SLOW_STEP);
              end
            end
            MODE_START: begin
              sp_q  <= START_SETPOINT;
              run_q <= 1'b1;
            end
            MODE_STOP: begin
              if (avg_q == '0) begin
                run_q <= 1'b0;
                sp_q  <= '0;
              end
            end
            default: ;
          endcase
        end
        CMD_SP_UPDATE: begin
          sum_q        <= sum_q - SUM_W'(old_val) + SUM_W'(prod_q[20:0]);
          vld_q[pos_q] <= 1'b1;
          pos_q        <= pos_next;
          edge_q       <= '0;
        end
        CMD_SP_AVG: begin
          if (filled_q) begin
            avg_q <= (rem >= SUM_W'(WINDOW_DEPTH)) ? 21'(q0_q + 1'b1) : 21'(q0_q);
          end else begin
            avg_q <= rpm_q;
          end
          if (pos_q == PW'(WINDOW_DEPTH - 1)) begin
            filled_q <= 1'b1;
          end
        end
        CMD_CT_ERR: begin
          integ_q <= integ_d;
          lerr_q  <= err_d;
        end
        CMD_CT_DUTY: begin
          duty_q <= prod_q[DUTY_SHIFT +: 6];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step == CMD_SP_MUL25) begin
      rd_q  <= win_mem[pos_q];
      rdv_q <= vld_q[pos_q];
    end
    if (cmd_i.step == CMD_SP_UPDATE) begin
      win_mem[pos_q] <= prod_q[20:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.step)
      CMD_LOAD: begin
        mode_q   <= in_mode_i;
        target_q <= in_target_i;
        estop_q  <= in_estop_i;
      end
      CMD_SP_UPDATE: rpm_q <= prod_q[20:0];
      CMD_SP_REMMUL: q0_q  <= prod_q[32 +: SUM_W];
      CMD_CT_ERR: begin
        err_q  <= err_d;
        diff_q <= 24'(err_d) - 24'(lerr_q);
      end
      CMD_CT_MULI: acc_q <= prod_q[63:0];
      CMD_CT_MULD: acc_q <= acc_q + $signed(prod_q[63:0]);
      CMD_CT_SUB:  acc_q <= acc_q - $signed(prod_q[63:0]);
      CMD_CT_CLAMP: begin
        if (acc_q > hi_lim) begin
          clamp_q <= {cfg_i.max_cmd, 16'd0};
        end else if (acc_q < lo_lim) begin
          clamp_q <= {cfg_i.min_cmd, 16'd0};
        end else begin
          clamp_q <= acc_q[28:0];
        end
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_data_o <= {6'd0, run_q, duty_q, sp_q, avg_q};
      out_user_o <= (mode_q == MODE_CTRL);
    end
  end

endmodule

>>> hw/rtl/msp_ctrl.sv
`timescale 1ns / 1ps
`include "motor_speed_pid_controller_unit_macros.svh"
module msp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  msp_pkg::dp_status_t status_i,
  output msp_pkg::ctl_cmd_t   cmd_o
);
  import msp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o.step     = CMD_NONE;
    cmd_o.load_out = 1'b0;
    out_valid_d    = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.step = CMD_LOAD;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status_i.mode)
          MODE_SPEED: begin
            cmd_o.step = CMD_SP_MUL25;
            state_d    = ST_SP_RECIP3;
          end
          MODE_CTRL: begin
            cmd_o.step = CMD_CT_ERR;
            state_d    = ST_CT_MULP;
          end
          default: begin
            cmd_o.step = CMD_EXEC;
            state_d    = ST_DONE;
          end
        endcase
      end
      ST_SP_RECIP3: begin
        cmd_o.step = CMD_SP_RECIP3;
        state_d    = ST_SP_MUL60;
      end
      ST_SP_MUL60: begin
        cmd_o.step = CMD_SP_MUL60;
        state_d    = ST_SP_UPDATE;
      end
      ST_SP_UPDATE: begin
        cmd_o.step = CMD_SP_UPDATE;
        state_d    = ST_SP_DIVMUL;
      end
      ST_SP_DIVMUL: begin
        cmd_o.step = CMD_SP_DIVMUL;
        state_d    = ST_SP_REMMUL;
      end
      ST_SP_REMMUL: begin
        cmd_o.step = CMD_SP_REMMUL;
        state_d    = ST_SP_AVG;
      end
      ST_SP_AVG: begin
        cmd_o.step = CMD_SP_AVG;
        state_d    = ST_DONE;
      end
      ST_CT_MULP: begin
        cmd_o.step = CMD_CT_MULP;
        state_d    = ST_CT_MULI;
      end
      ST_CT_MULI: begin
        cmd_o.step = CMD_CT_MULI;
        state_d    = ST_CT_MULD;
      end
      ST_CT_MULD: begin
        cmd_o.step = CMD_CT_MULD;
        state_d    = ST_CT_SUB;
      end
      ST_CT_SUB: begin
        cmd_o.step = CMD_CT_SUB;
        state_d    = ST_CT_CLAMP;
      end
      ST_CT_CLAMP: begin
        cmd_o.step = CMD_CT_CLAMP;
        state_d    = ST_CT_DUTYMUL;
      end
      ST_CT_DUTYMUL: begin
        cmd_o.step = CMD_CT_DUTYMUL;
        state_d    = ST_CT_DUTY;
      end
      ST_CT_DUTY: begin
        cmd_o.step = CMD_CT_DUTY;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `MSP_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni,
    state_q == ST_IDLE && in_valid_i, state_q != ST_IDLE)
  `MSP_ASSERT_NEXT(a_done_waits, clk_i, rst_ni,
    state_q == ST_DONE && !out_free, state_q == ST_DONE)
  `MSP_ASSERT_NEXT(a_done_presents, clk_i, rst_ni,
    state_q == ST_DONE && out_free, out_valid_q && state_q == ST_IDLE)

endmodule

>>> hw/rtl/motor_speed_pid_controller_unit.sv
`timescale 1ns / 1ps
// Hall, ramp, start, stop check and unused modes execute in decode; speed and control ticks
// step through their own states (one shared 33x33 multiplier, one pass each).
// Throughput: one transaction at a time; the next one is taken while a result waits.
// Reset (rst_ni low, asynchronous) clears the FSM, speed and control state, window valid bits
// and gains (not the window memory); the upper output clamp resets to 5820.
module motor_speed_pid_controller_unit #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // target_speed[12:0], emergency_stop[13], zero pad
  input  logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // filtered_speed, ramp_setpoint, duty, running, pad
  output logic        m_axis_tuser,  // duty_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import msp_pkg::*;

  cfg_t       cfg;
  ctl_cmd_t   cmd;
  dp_status_t status;

  msp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  msp_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg),
    .in_mode_i   (s_axis_tuser),
    .in_target_i (s_axis_tdata[12:0]),
    .in_estop_i  (s_axis_tdata[13]),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

>>> test/motor_speed_pid_controller_unit_test.sv
`timescale 1ns / 1ps
module motor_speed_pid_controller_unit_test;
  import msp_pkg::*;

  localparam int DEPTH = 8;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int LATENCY = 12;

  typedef struct packed {
    logic [20:0]        speed;
    logic signed [13:0] setpoint;
    logic [5:0]         duty;
    logic               duty_valid;
    logic               running;
  } speed_result_t;

  class speed_ctrl_scoreboard;
    logic signed [31:0] kp, ki, kd;
    logic [12:0]        max_cmd, min_cmd;
    logic [11:0]        edges;
    logic [20:0]        window[DEPTH];
    logic [23:0]        wsum;
    logic [2:0]         wpos;
    bit                 filled;
    logic [20:0]        avg;
    logic signed [13:0] sp;
    logic signed [31:0] isum;
    logic signed [22:0] last_err;
    logic [5:0]         duty;
    bit                 run;
    speed_result_t      expected_q[$];
    int                 mismatches;
    int                 checked;
    int                 ctrl_seen;

    function new();
      kp = 0; ki = 0; kd = 0; max_cmd = MAX_CMD_RESET; min_cmd = 0;
      edges = 0; wsum = 0; wpos = 0; filled = 0; avg = 0; sp = 0;
      isum = 0; last_err = 0; duty = 0; run = 0;
      foreach (window[i]) window[i] = 0;
      mismatches = 0; checked = 0; ctrl_seen = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_KP:  kp = v;
        REG_KI:  ki = v;
        REG_KD:  kd = v;
        REG_MAX: max_cmd = v[12:0];
        REG_MIN: min_cmd = v[12:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [2:0] mode, logic [12:0] target, logic estop);
      int unsigned   rpm;
      logic [2:0]    pos;
      longint        err, acc, outv, hi, lo;
      speed_result_t r;
      bit            valid;
      valid = 0;
      case (mode)
        MODE_HALL: if (run && edges < EDGE_MAX) edges = edges + 1;
        MODE_SPEED: begin
          rpm = ((int'(edges) * 200) / 24) * 60;
          pos = wpos;
          edges = 0;
          wsum = wsum - window[pos] + rpm[23:0];
          window[pos] = rpm[20:0];
          wpos = pos + 1;
          if (filled) avg = wsum / DEPTH;
          else avg = rpm[20:0];
          if (wpos == DEPTH - 1) filled = 1;
        end
        MODE_RAMP: begin
          if (int'(sp) < int'(target)) sp = sp + 1;
          else if (int'(sp) > int'(target)) sp = sp - (estop ? FAST_STEP : SLOW_STEP);
        end
        MODE_CTRL: begin
          err = longint'(sp) - longint'(avg);
          acc = longint'(isum) + err;
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
          isum = acc[31:0];
          hi = longint'(max_cmd) * 65536;
          lo = longint'(min_cmd) * 65536;
          outv = longint'(kp) * err + longint'(ki) * longint'(isum)
                 - longint'(kd) * (err - longint'(last_err));
          if (outv > hi) outv = hi;
          else if (outv < lo) outv = lo;
          outv = (outv * 2) / (64'sd485 * 64'sd65536);
          duty = outv[5:0];
          last_err = err[22:0];
          valid = 1;
          ctrl_seen++;
        end
        MODE_START: begin
          sp = START_SETPOINT;
          run = 1;
        end
        MODE_STOP: if (avg == 0) begin
          run = 0;
          sp = 0;
        end
        default: ;
      endcase
      r.speed = avg; r.setpoint = sp; r.duty = duty; r.duty_valid = valid; r.running = run;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [47:0] data, logic user);
      speed_result_t e, a;
      a.speed = data[20:0]; a.setpoint = data[34:21]; a.duty = data[40:35];
      a.running = data[41]; a.duty_valid = user;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", a);
        return;
      end
      e = expected_q.pop_front();
      if (a.speed !== e.speed || a.setpoint !== e.setpoint || a.duty !== e.duty ||
          a.duty_valid !== e.duty_valid || a.running !== e.running) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp speed %0d sp %0d duty %0d dv %0d run %0d, got %0d %0d %0d %0d %0d",
                   checked, e.speed, e.setpoint, e.duty, e.duty_valid, e.running,
                   a.speed, a.setpoint, a.duty, a.duty_valid, a.running);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  speed_ctrl_scoreboard sb = new();
  int  cycles = 0;
  int  sent = 0;
  bit  no_idle = 0;
  bit  long_hold_done = 0;
  int  hold_cnt = 0;
  int  stall_cnt = 0;

  motor_speed_pid_controller_unit #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);

  // receiver: random stalls, one long hold once traffic is under way
  initial begin
    m_axis_tready <= 0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        m_axis_tready <= 0;
        hold_cnt--;
      end else if (!long_hold_done && sent >= 400) begin
        long_hold_done = 1;
        hold_cnt = 300;
        m_axis_tready <= 0;
      end else if (stall_cnt > 0) begin
        m_axis_tready <= 0;
        stall_cnt--;
      end else if (no_idle || $urandom_range(99) < 75) begin
        m_axis_tready <= 1;
      end else begin
        m_axis_tready <= 0;
        stall_cnt = ($urandom_range(99) < 93) ? $urandom_range(3) : $urandom_range(40, 10);
      end
    end
  end

  task automatic send_item(logic [2:0] mode, logic [12:0] target, logic estop);
    int gap;
    s_axis_tvalid <= 1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {2'b00, estop, target};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(mode, target, estop);
    sent++;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 35)
      gap = ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_items(int count);
    int r;
    logic [12:0] tgt;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      tgt = ($urandom_range(3) == 0) ? 13'($urandom_range(8191)) : 13'($urandom_range(1500));
      if (r < 40)      send_item(MODE_HALL, tgt, 1'($urandom));
      else if (r < 52) send_item(MODE_SPEED, tgt, 1'($urandom));
      else if (r < 70) send_item(MODE_RAMP, tgt, 1'($urandom));
      else if (r < 88) send_item(MODE_CTRL, tgt, 1'($urandom));
      else if (r < 93) send_item(MODE_START, tgt, 1'($urandom));
      else if (r < 98) send_item(MODE_STOP, tgt, 1'($urandom));
      else             send_item(3'($urandom_range(7, 6)), tgt, 1'($urandom));
    end
  endtask

  task automatic load_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                            logic [12:0] hi, logic [12:0] lo);
    apb_write(REG_KP, p);
    apb_write(REG_KI, i);
    apb_write(REG_KD, d);
    apb_write(REG_MAX, {19'd0, hi});
    apb_write(REG_MIN, {19'd0, lo});
  endtask

  initial begin
    rst_ni = 0;
    s_axis_tvalid <= 0; s_axis_tdata <= 0; s_axis_tuser <= 0;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: defaults, stopped behavior, unused modes, ramp limits
    send_item(MODE_STOP, 0, 0);
    send_item(MODE_CTRL, 0, 0);
    send_item(MODE_HALL, 0, 0);
    send_item(3'd6, 13'h1fff, 1);
    send_item(3'd7, 0, 0);
    send_item(MODE_RAMP, 13'h1fff, 0);
    send_item(MODE_RAMP, 0, 1);
    send_item(MODE_RAMP, 0, 1);
    send_item(MODE_RAMP, 0, 0);
    send_item(MODE_RAMP, 0, 0);
    send_item(MODE_START, 0, 0);
    send_item(MODE_RAMP, 13'd700, 1);
    send_item(MODE_RAMP, 13'h1fff, 0);
    send_item(MODE_RAMP, 0, 1);
    send_item(MODE_CTRL, 0, 0);
    // burst of edges, then convert
    for (int i = 0; i < 40; i++) send_item(MODE_HALL, 13'($urandom), 1'($urandom));
    send_item(MODE_SPEED, 0, 0);
    send_item(MODE_CTRL, 0, 0);
    send_item(MODE_STOP, 0, 0);
    drain();

    load_gains(32'sd5 << 16, 32'sd1 << 12, 32'sd1 << 15, 13'd5820, 13'd0);
    random_items(250);
    drain();
    load_gains(32'h7fffffff, 32'h7fffffff, 32'h80000000, 13'h1fff, 13'd0);
    no_idle = 1;
    random_items(250);
    no_idle = 0;
    drain();
    load_gains(32'h80000000, 32'h80000000, 32'h7fffffff, 13'd0, 13'h1fff);
    random_items(200);
    drain();
    load_gains($urandom, $urandom, $urandom, 13'($urandom), 13'($urandom));
    random_items(150);
    drain();
    load_gains(32'($urandom_range(20)) << 16, 32'($urandom_range(4095)),
               32'($urandom_range(65535)), 13'd6000, 13'd300);
    random_items(300);
    drain();

    $display("%0d items sent, %0d results checked, %0d control ticks, five gain settings",
             sent, sb.checked, sb.ctrl_seen);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
